[sv/lrfb_pkg.sv]
// lrfb_pkg: shared types, constants and tables of the LED ring frame builder.
// Holds the level ROM and the per-ring LED order used to pack driver words.
// No dependencies.

package lrfb_pkg;

   localparam int FRAME_BYTES   = 36;
   localparam int HALF_BYTES    = 18;
   localparam int RING_LEDS     = 12;
   localparam int RING_WORDS    = HALF_BYTES / 3;
   localparam int WRITE_LIMIT   = 20;
   localparam int LEVEL_COUNT   = 10;
   localparam int ROM_ROWS      = 64;
   localparam int PWM_BITS      = 12;
   localparam int LEVEL_BITS    = 4;

   typedef enum logic {
      KIND_WRITE  = 1'b0,
      KIND_RENDER = 1'b1
   } kind_type;

   localparam logic [2:0] TARGET_MIN        = 3'd1;
   localparam logic [2:0] TARGET_MAX        = 3'd4;
   localparam logic [2:0] TARGET_BLANK_LEFT = 3'd4;

   typedef logic [PWM_BITS-1:0]   pwm_type;
   typedef logic [LEVEL_BITS-1:0] level_type;
   typedef logic [7:0]            byte_type;
   typedef pwm_type  [LEVEL_COUNT-1:0] palette_type;
   typedef byte_type [FRAME_BYTES-1:0] frame_type;
   typedef logic [5:0]            position_type;

   // One ROM row per entry, LED column k in nibble k.
   localparam logic [47:0] LEVEL_ROM [ROM_ROWS] = '{
      48'h000000000001, 48'h000000000002, 48'h000000000003, 48'h000000000014,
      48'h000000000015, 48'h000000000016, 48'h000000000027, 48'h000000000038,
      48'h000000000149, 48'h000000000158, 48'h000000000167, 48'h000000000276,
      48'h000000000385, 48'h000000001494, 48'h000000001583, 48'h000000001672,
      48'h000000002761, 48'h000000003851, 48'h000000014941, 48'h000000015830,
      48'h000000016720, 48'h000000027610, 48'h000000038510, 48'h000000149410,
      48'h000000158300, 48'h000000167200, 48'h000000276100, 48'h000000385100,
      48'h000001494100, 48'h000001583000, 48'h000001672000, 48'h000002761000,
      48'h000003851000, 48'h000014941000, 48'h000015830000, 48'h000016720000,
      48'h000027610000, 48'h000038510000, 48'h000149410000, 48'h000158300000,
      48'h000167200000, 48'h000276100000, 48'h000385100000, 48'h001494100000,
      48'h001583000000, 48'h001672000000, 48'h002761000000, 48'h003851000000,
      48'h014941000000, 48'h015830000000, 48'h016720000000, 48'h027610000000,
      48'h038510000000, 48'h149410000000, 48'h158300000000, 48'h167200000000,
      48'h276100000000, 48'h385100000000, 48'h494100000000, 48'h583000000000,
      48'h672000000000, 48'h761000000000, 48'h851000000000, 48'h961000000000
   };

   // LED columns feeding the upper and lower 12 bits of each 24-bit word.
   localparam int LEFT_FIRST   [RING_WORDS] = '{2, 4, 6, 1, 11, 8};
   localparam int LEFT_SECOND  [RING_WORDS] = '{3, 5, 7, 0, 10, 9};
   localparam int RIGHT_FIRST  [RING_WORDS] = '{2, 1, 11, 4, 6, 8};
   localparam int RIGHT_SECOND [RING_WORDS] = '{3, 0, 10, 5, 7, 9};

endpackage

[sv/lrfb_frame_map.sv]
// lrfb_frame_map: maps two ROM rows through the palette into the 36 frame bytes.
// Pure combinational; uses lrfb_pkg for the level ROM, LED order and types.

module lrfb_frame_map (
   input  lrfb_pkg::position_type left_position,
   input  lrfb_pkg::position_type right_position,
   input  logic                   blank_left,
   input  lrfb_pkg::palette_type  palette,
   output lrfb_pkg::frame_type    frame
);

   logic [47:0] left_row;
   logic [47:0] right_row;

   assign left_row  = lrfb_pkg::LEVEL_ROM[left_position];
   assign right_row = lrfb_pkg::LEVEL_ROM[right_position];

   function automatic lrfb_pkg::pwm_type to_pwm(lrfb_pkg::level_type lvl,
                                                lrfb_pkg::palette_type pal);
      lrfb_pkg::pwm_type result;
      result = '0;
      if (lvl < lrfb_pkg::LEVEL_BITS'(lrfb_pkg::LEVEL_COUNT)) begin
         result = pal[lvl];
      end
      return result;
   endfunction

   for (genvar w = 0; w < lrfb_pkg::RING_WORDS; w++) begin : g_word
      logic [23:0] left_word;
      logic [23:0] right_word;

      assign left_word = {
         to_pwm(left_row[lrfb_pkg::LEFT_FIRST[w]*4 +: 4], palette),
         to_pwm(left_row[lrfb_pkg::LEFT_SECOND[w]*4 +: 4], palette)};
      assign right_word = {
         to_pwm(right_row[lrfb_pkg::RIGHT_FIRST[w]*4 +: 4], palette),
         to_pwm(right_row[lrfb_pkg::RIGHT_SECOND[w]*4 +: 4], palette)};

      // most significant byte first; target four zeroes the left half
      assign frame[w*3 + 0] = blank_left ? 8'h00 : left_word[23:16];
      assign frame[w*3 + 1] = blank_left ? 8'h00 : left_word[15:8];
      assign frame[w*3 + 2] = blank_left ? 8'h00 : left_word[7:0];
      assign frame[lrfb_pkg::HALF_BYTES + w*3 + 0] = right_word[23:16];
      assign frame[lrfb_pkg::HALF_BYTES + w*3 + 1] = right_word[15:8];
      assign frame[lrfb_pkg::HALF_BYTES + w*3 + 2] = right_word[7:0];
   end

endmodule

[sv/led_ring_frame_builder.sv]
// led_ring_frame_builder: top level, palette store, item register and byte shifter.
// Depends on lrfb_pkg and lrfb_frame_map.
//
// Channel | Dir | Handshake          | Payload
// req     | in  | tvalid/tready      | tuser = kind, tdata = palette write or render item
// rsp     | out | tvalid/tready/tlast| tdata = frame byte, index, driver; tlast = last byte
//
// A render item with a valid target yields 36 beats, one per cycle while rsp_tready
// is high; the 36-byte frame shift register sets that figure. The next render loads
// in the cycle the last beat is taken: no gap.
// Palette writes and dropped renders leave the item register without waiting for the shifter.
// Reset (synchronous, active high) clears the palette and all valid/busy state.
// A stalled rsp holds the frame; a render waiting behind it holds the item register.

module led_ring_frame_builder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic        req_tuser,   // kind
   // [4:0] palette_index, [16:5] palette_value, [19:17] target,
   // [25:20] left_position, [31:26] right_position
   input  logic [31:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] frame_byte, [13:8] byte_index, [16:14] driver_select, [23:17] zero
   output logic [23:0] rsp_tdata,
   output logic        rsp_tlast    // last_byte
);

   // item register
   logic                   in_valid_ff, in_valid_in;
   lrfb_pkg::kind_type     in_kind_ff;
   logic [4:0]             in_index_ff;
   lrfb_pkg::pwm_type      in_value_ff;
   logic [2:0]             in_target_ff;
   lrfb_pkg::position_type in_lpos_ff;
   lrfb_pkg::position_type in_rpos_ff;

   // palette: levels only reach 0..9, so entries 10..19 are never read and not kept
   lrfb_pkg::palette_type  palette_ff, palette_in;

   // frame shifter
   logic                   busy_ff, busy_in;
   logic [5:0]             count_ff, count_in;
   logic [2:0]             drv_ff, drv_in;
   lrfb_pkg::frame_type    frame_ff, frame_in;
   lrfb_pkg::frame_type    frame_built;

   logic req_fire, rsp_fire, last_fire, engine_free;
   logic render_ok, in_advance, load, write_ok;

   assign req_fire    = req_tvalid & req_tready;
   assign rsp_fire    = busy_ff & rsp_tready;
   assign last_fire   = rsp_fire & (count_ff == 6'(lrfb_pkg::FRAME_BYTES - 1));
   assign engine_free = ~busy_ff | last_fire;

   assign render_ok = (in_kind_ff == lrfb_pkg::KIND_RENDER) &&
                      (in_target_ff >= lrfb_pkg::TARGET_MIN) &&
                      (in_target_ff <= lrfb_pkg::TARGET_MAX);
   assign write_ok  = in_valid_ff && (in_kind_ff == lrfb_pkg::KIND_WRITE) &&
                      (in_index_ff < 5'(lrfb_pkg::LEVEL_COUNT));

   // writes and dropped renders pass at once; a render waits for the shifter
   assign in_advance = in_valid_ff & (~render_ok | engine_free);
   assign load       = in_valid_ff & render_ok & engine_free;
   assign req_tready = ~in_valid_ff | in_advance;

   lrfb_frame_map u_frame_map (
      .left_position  (in_lpos_ff),
      .right_position (in_rpos_ff),
      .blank_left     (in_target_ff == lrfb_pkg::TARGET_BLANK_LEFT),
      .palette        (palette_ff),
      .frame          (frame_built)
   );

   always_comb begin
      in_valid_in = req_fire | (in_valid_ff & ~in_advance);

      palette_in = palette_ff;
      if (write_ok) begin
         palette_in[in_index_ff[lrfb_pkg::LEVEL_BITS-1:0]] = in_value_ff;
      end

      busy_in  = busy_ff;
      count_in = count_ff;
      drv_in   = drv_ff;
      frame_in = frame_ff;
      priority if (load) begin
         busy_in  = 1'b1;
         count_in = '0;
         drv_in   = in_target_ff;
         frame_in = frame_built;
      end else if (rsp_fire) begin
         busy_in  = ~last_fire;
         count_in = count_ff + 6'd1;
         frame_in = frame_ff >> 8;   // advance to the next byte
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         palette_ff  <= '0;
         busy_ff     <= 1'b0;
         count_ff    <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         palette_ff  <= palette_in;
         busy_ff     <= busy_in;
         count_ff    <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_kind_ff   <= lrfb_pkg::kind_type'(req_tuser);
         in_index_ff  <= req_tdata[4:0];
         in_value_ff  <= req_tdata[16:5];
         in_target_ff <= req_tdata[19:17];
         in_lpos_ff   <= req_tdata[25:20];
         in_rpos_ff   <= req_tdata[31:26];
      end
      drv_ff   <= drv_in;
      frame_ff <= frame_in;
   end

   assign rsp_tvalid = busy_ff;
   assign rsp_tdata  = {7'd0, drv_ff, count_ff, frame_ff[0]};
   assign rsp_tlast  = count_ff == 6'(lrfb_pkg::FRAME_BYTES - 1);

   // a beat inside a frame is followed by the next byte of the same frame
   a_index_steps: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && !rsp_tlast) |=>
         (rsp_tvalid && count_ff == $past(count_ff) + 6'd1 && drv_ff == $past(drv_ff)))
      else $error("byte index or driver broke within a frame");

   // after the last beat the shifter is idle or starts a new frame at byte zero
   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && rsp_tlast) |=> (!rsp_tvalid || count_ff == 6'd0))
      else $error("frame did not restart at byte zero");

   // a render with a valid target never leaves the item register while a frame is held
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !rsp_tready) |-> !load)
      else $error("frame overwritten while stalled");

endmodule

[dv/tb_led_ring_frame_builder.sv]
`timescale 1ns / 1ps
// tb_led_ring_frame_builder: self-checking bench for the LED ring frame builder.
// Sends palette writes and renders on req, predicts every frame byte, checks rsp.
// Depends on lrfb_pkg and led_ring_frame_builder.

module tb_led_ring_frame_builder;

   localparam int CLOCK_HALF    = 6;
   localparam int RESET_CYCLES  = 6;
   // Slowest correct run is roughly 400 renders x 36 beats with 6 percent stalls
   // on both sides plus one long hold-off; this is several times that.
   localparam int CYCLE_LIMIT   = 250000;
   localparam int DRAIN_CYCLES  = 40;
   localparam int RANDOM_ITEMS  = 400;
   localparam int IDLE_PERCENT  = 6;
   localparam int MAX_REPORTS   = 10;
   localparam int PALETTE_SLOTS = 32;
   localparam int HOLD_CYCLES   = 300;

   // One expected rsp beat, one per frame byte.
   typedef struct packed {
      lrfb_pkg::byte_type frame_byte;
      logic [5:0]         byte_index;
      logic [2:0]         driver;
      logic               last;
   } frame_beat_type;

   // Level table written row by row, LED column 0 in the top nibble.
   localparam logic [47:0] RING_LEVELS [64] = '{
      48'h100000000000, 48'h200000000000, 48'h300000000000, 48'h410000000000,
      48'h510000000000, 48'h610000000000, 48'h720000000000, 48'h830000000000,
      48'h941000000000, 48'h851000000000, 48'h761000000000, 48'h672000000000,
      48'h583000000000, 48'h494100000000, 48'h385100000000, 48'h276100000000,
      48'h167200000000, 48'h158300000000, 48'h149410000000, 48'h038510000000,
      48'h027610000000, 48'h016720000000, 48'h015830000000, 48'h014941000000,
      48'h003851000000, 48'h002761000000, 48'h001672000000, 48'h001583000000,
      48'h001494100000, 48'h000385100000, 48'h000276100000, 48'h000167200000,
      48'h000158300000, 48'h000149410000, 48'h000038510000, 48'h000027610000,
      48'h000016720000, 48'h000015830000, 48'h000014941000, 48'h000003851000,
      48'h000002761000, 48'h000001672000, 48'h000001583000, 48'h000001494100,
      48'h000000385100, 48'h000000276100, 48'h000000167200, 48'h000000158300,
      48'h000000149410, 48'h000000038510, 48'h000000027610, 48'h000000016720,
      48'h000000015830, 48'h000000014941, 48'h000000003851, 48'h000000002761,
      48'h000000001672, 48'h000000001583, 48'h000000001494, 48'h000000000385,
      48'h000000000276, 48'h000000000167, 48'h000000000158, 48'h000000000169
   };

   // LED pair (upper 12 bits, lower 12 bits) of each 24-bit driver word.
   localparam int LEFT_PAIRS  [6][2] = '{'{2, 3}, '{4, 5}, '{6, 7}, '{1, 0}, '{11, 10}, '{8, 9}};
   localparam int RIGHT_PAIRS [6][2] = '{'{2, 3}, '{1, 0}, '{11, 10}, '{4, 5}, '{6, 7}, '{8, 9}};

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic        req_tuser  = 1'b0;  // kind
   // [4:0] palette_index, [16:5] palette_value, [19:17] target,
   // [25:20] left_position, [31:26] right_position
   logic [31:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // [7:0] frame_byte, [13:8] byte_index, [16:14] driver_select, [23:17] zero
   logic [23:0] rsp_tdata;
   logic        rsp_tlast;          // last_byte

   lrfb_pkg::pwm_type palette_copy [PALETTE_SLOTS];
   frame_beat_type    pending_bytes [$];
   int                mismatches  = 0;
   int                cycle_count = 0;
   int                hold_left   = 0;
   bit                calm        = 1'b0;

   led_ring_frame_builder DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   // Watchdog: a hung handshake or a missing beat ends the run here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Frame prediction
   // ---------------------------------------------------------------------------

   // Brightness of one LED: look up its level in the row, then map through the palette.
   function automatic lrfb_pkg::pwm_type led_pwm(logic [5:0] row, int col);
      logic [3:0] level;
      level = RING_LEVELS[row][47 - 4 * col -: 4];
      return palette_copy[level];
   endfunction

   // Apply one accepted req beat: update the palette copy, or queue the 36 frame
   // bytes a render produces. Writes at or above the write limit and renders to a
   // target outside 1..4 leave everything as it was.
   function automatic void render_frame(lrfb_pkg::kind_type kind, logic [31:0] data);
      logic [4:0]         slot;
      lrfb_pkg::pwm_type  value;
      logic [2:0]         target;
      logic [5:0]         left_row;
      logic [5:0]         right_row;
      logic [23:0]        word;
      lrfb_pkg::byte_type frame [lrfb_pkg::FRAME_BYTES];
      frame_beat_type     beat;
      {right_row, left_row, target, value, slot} = data;
      if (kind == lrfb_pkg::KIND_WRITE) begin
         if (slot < lrfb_pkg::WRITE_LIMIT) palette_copy[slot] = value;
         return;
      end
      if (target < lrfb_pkg::TARGET_MIN || target > lrfb_pkg::TARGET_MAX) return;
      for (int w = 0; w < lrfb_pkg::RING_WORDS; w++) begin
         word = {led_pwm(left_row, LEFT_PAIRS[w][0]), led_pwm(left_row, LEFT_PAIRS[w][1])};
         frame[3 * w]     = word[23:16];
         frame[3 * w + 1] = word[15:8];
         frame[3 * w + 2] = word[7:0];
         word = {led_pwm(right_row, RIGHT_PAIRS[w][0]), led_pwm(right_row, RIGHT_PAIRS[w][1])};
         frame[lrfb_pkg::HALF_BYTES + 3 * w]     = word[23:16];
         frame[lrfb_pkg::HALF_BYTES + 3 * w + 1] = word[15:8];
         frame[lrfb_pkg::HALF_BYTES + 3 * w + 2] = word[7:0];
      end
      for (int i = 0; i < lrfb_pkg::FRAME_BYTES; i++) begin
         // target four blanks the whole left half
         beat.frame_byte = (target == lrfb_pkg::TARGET_BLANK_LEFT && i < lrfb_pkg::HALF_BYTES)
                           ? 8'h00 : frame[i];
         beat.byte_index = i[5:0];
         beat.driver     = target;
         beat.last       = (i == lrfb_pkg::FRAME_BYTES - 1);
         pending_bytes.push_back(beat);
      end
   endfunction

   // ---------------------------------------------------------------------------
   // Result checking
   // ---------------------------------------------------------------------------

   function automatic void compare_field(string field, int want, int got);
      if (want == got) return;
      if (mismatches < MAX_REPORTS)
         $display("[%0t] %s mismatch: expected 0x%0h, actual 0x%0h", $realtime, field, want, got);
      mismatches++;
   endfunction

   // Check one rsp beat against the oldest queued frame byte.
   function automatic void check_beat();
      frame_beat_type want;
      if (pending_bytes.size() == 0) begin
         if (mismatches < MAX_REPORTS)
            $display("[%0t] unexpected beat: tdata 0x%0h tlast %0b",
                     $realtime, rsp_tdata, rsp_tlast);
         mismatches++;
         return;
      end
      want = pending_bytes.pop_front();
      compare_field("frame_byte",    want.frame_byte, rsp_tdata[7:0]);
      compare_field("byte_index",    want.byte_index, rsp_tdata[13:8]);
      compare_field("driver_select", want.driver,     rsp_tdata[16:14]);
      compare_field("tdata padding", 0,               rsp_tdata[23:17]);
      compare_field("last_byte",     want.last,       rsp_tlast);
   endfunction

   // Receiver: take beats, stall about 6 percent of cycles unless calm, and hold
   // off completely while hold_left counts down.
   initial begin : rsp_sink
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid === 1'b1 && rsp_tready) check_beat();
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else begin
            rsp_tready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------

   function automatic logic [31:0] pack_req(logic [4:0] slot, lrfb_pkg::pwm_type value,
                                            logic [2:0] target,
                                            logic [5:0] left_row, logic [5:0] right_row);
      return {right_row, left_row, target, value, slot};
   endfunction

   // Offer one beat on req, hold it until taken, then predict. Valid stays high on
   // exit so back-to-back beats need no bubble.
   task automatic send_item(lrfb_pkg::kind_type kind, logic [31:0] data);
      if (!calm) begin
         while ($urandom_range(99) < IDLE_PERCENT) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= data;
      do @(posedge clock); while (req_tready !== 1'b1);
      render_frame(kind, data);
   endtask

   // A render straight after reset must come out all zero.
   task automatic test_cleared_palette();
      send_item(lrfb_pkg::KIND_RENDER, pack_req(5'd31, 12'hFFF, 3'd1, 6'd0, 6'd63));
   endtask

   // Fill every palette entry a level can reach, extremes included, and render.
   task automatic test_palette_extremes();
      lrfb_pkg::pwm_type levels [lrfb_pkg::LEVEL_COUNT];
      levels = '{12'h000, 12'hFFF, 12'h800, 12'h001, 12'hA5A,
                 12'h5A5, 12'h7FE, 12'h123, 12'hF0F, 12'hFFF};
      for (int l = 0; l < lrfb_pkg::LEVEL_COUNT; l++)
         send_item(lrfb_pkg::KIND_WRITE, pack_req(l[4:0], levels[l], 3'd0, 6'd0, 6'd0));
      send_item(lrfb_pkg::KIND_RENDER, pack_req(5'd0, 12'h000, 3'd1, 6'd0, 6'd63));
      send_item(lrfb_pkg::KIND_RENDER, pack_req(5'd0, 12'h000, 3'd2, 6'd63, 6'd0));
   endtask

   // Writes past the reachable palette entries: 10, 19, 20 and 31 are all dropped.
   task automatic test_high_index_writes();
      send_item(lrfb_pkg::KIND_WRITE, pack_req(5'd10, 12'h456, 3'd7, 6'd63, 6'd63));
      send_item(lrfb_pkg::KIND_WRITE, pack_req(5'd19, 12'hABC, 3'd0, 6'd0, 6'd0));
      send_item(lrfb_pkg::KIND_WRITE, pack_req(5'd20, 12'h000, 3'd1, 6'd8, 6'd13));
      send_item(lrfb_pkg::KIND_WRITE, pack_req(5'd31, 12'hFFF, 3'd4, 6'd63, 6'd63));
      send_item(lrfb_pkg::KIND_RENDER, pack_req(5'd0, 12'h000, 3'd3, 6'd8, 6'd13));
   endtask

   // Renders to targets outside 1..4 produce no beats.
   task automatic test_dropped_targets();
      logic [2:0] bad_targets [4];
      bad_targets = '{3'd0, 3'd5, 3'd6, 3'd7};
      foreach (bad_targets[t])
         send_item(lrfb_pkg::KIND_RENDER,
                   pack_req(5'd31, 12'hFFF, bad_targets[t], 6'd63, 6'd63));
   endtask

   // Target four zeroes the left half and still builds the right half.
   task automatic test_blank_left();
      send_item(lrfb_pkg::KIND_RENDER,
                pack_req(5'd0, 12'h000, lrfb_pkg::TARGET_BLANK_LEFT, 6'd13, 6'd58));
   endtask

   // Stall rsp for a long stretch while renders keep coming, so the block fills
   // and drops req_tready; then release and let it drain.
   task automatic test_backpressure();
      calm      = 1'b1;
      hold_left = HOLD_CYCLES;
      for (int n = 0; n < 6; n++)
         send_item(lrfb_pkg::KIND_RENDER,
                   pack_req(5'($urandom()), 12'($urandom()),
                            3'($urandom_range(lrfb_pkg::TARGET_MAX, lrfb_pkg::TARGET_MIN)),
                            6'($urandom_range(63)), 6'($urandom_range(63))));
      // drop valid so the last beat is not taken twice while waiting
      req_tvalid <= 1'b0;
      while (hold_left != 0) @(posedge clock);
      calm = 1'b0;
   endtask

   // Mostly valid renders and writes to the reachable palette entries, with some
   // writes anywhere and renders to any target as noise. A middle stretch runs
   // with no idling on either side.
   task automatic test_random_traffic();
      int                 pick;
      logic [31:0]        data;
      lrfb_pkg::kind_type kind;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         calm = (n >= 150 && n < 230);
         pick = $urandom_range(99);
         data = $urandom();
         if (pick < 55) begin
            kind         = lrfb_pkg::KIND_RENDER;
            data[19:17]  = 3'($urandom_range(lrfb_pkg::TARGET_MAX, lrfb_pkg::TARGET_MIN));
         end else if (pick < 85) begin
            kind         = lrfb_pkg::KIND_WRITE;
            data[4:0]    = 5'($urandom_range(lrfb_pkg::LEVEL_COUNT - 1));
         end else if (pick < 93) begin
            kind         = lrfb_pkg::KIND_WRITE;
         end else begin
            kind         = lrfb_pkg::KIND_RENDER;
         end
         send_item(kind, data);
      end
      calm = 1'b0;
   endtask

   initial begin : main_sequence
      foreach (palette_copy[i]) palette_copy[i] = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_cleared_palette();
      test_palette_extremes();
      test_high_index_writes();
      test_dropped_targets();
      test_blank_left();
      test_backpressure();
      test_random_traffic();

      // Stop offering, drain every queued byte, then watch for strays.
      req_tvalid <= 1'b0;
      while (pending_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

[files.f]
sv/lrfb_pkg.sv
sv/lrfb_frame_map.sv
sv/led_ring_frame_builder.sv
dv/tb_led_ring_frame_builder.sv
